/* rtl/assert_macros.svh */
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define FSLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define FSLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/fslm_pkg.sv */
// ---------------------------------------------------------------------------
// fslm_pkg
// Shared types and constants of the false sharing line monitor.
// ---------------------------------------------------------------------------
package fslm_pkg;
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_LINE   = 2'd1;
  localparam logic [1:0] MODE_QREC   = 2'd2;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DROP     = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned HOT_DIV = 1000;
endpackage

/* rtl/fslm_ram.sv */
// ---------------------------------------------------------------------------
// fslm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fslm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/false_sharing_line_monitor_unit.sv */
// ---------------------------------------------------------------------------
// false_sharing_line_monitor_unit
// Thread/line access table with line and record queries.
// ---------------------------------------------------------------------------
// One beat in, one beat out. Entry state sits in one synchronous RAM and the
// IP lists in a second; valid bits are flops cleared at reset. Every beat walks
// all TABLE_ENTRIES entries one per cycle (one RAM read per cycle, pipelined),
// then for record accesses to an existing entry walks up to IP_SLOTS IP slots,
// each through S_IPRD and S_IPCHK, then writes back and loads the result,
// presents the output beat and returns to idle. Line queries skip the IP
// search and write-back; record queries read one IP slot in S_QIP and S_QIPW
// instead. The next beat is taken once the result beat has been accepted. The
// hotspot test sum > total/1000 is done as total < 1000*sum, so no divide is
// needed.
module false_sharing_line_monitor_unit
  import fslm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int THREAD_LIMIT  = 64,
  parameter int IP_SLOTS      = 8,
  parameter int LINE_BYTES    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [47:0] in_address,
  input  logic        in_access_is_write,
  input  logic [47:0] in_instr_pointer,
  input  logic [5:0]  in_thread_id,
  input  logic [2:0]  in_ip_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_thread_count,
  output logic [39:0] out_line_write_sum,
  output logic        out_hotspot,
  output logic        out_false_share,
  output logic [31:0] out_rec_reads,
  output logic [31:0] out_rec_writes,
  output logic [63:0] out_byte_mask,
  output logic [3:0]  out_write_ip_total,
  output logic [3:0]  out_read_ip_total,
  output logic [47:0] out_ip_value
);
`include "assert_macros.svh"
  localparam int EW  = $clog2(TABLE_ENTRIES);
  localparam int OW  = $clog2(LINE_BYTES);
  localparam int TGW = 48 - OW;
  localparam int SW  = (IP_SLOTS > 1) ? $clog2(IP_SLOTS) : 1;
  localparam int CW  = $clog2(IP_SLOTS + 1);
  localparam int IPD = TABLE_ENTRIES * IP_SLOTS;
  localparam int IW  = $clog2(IPD);
  localparam int RW  = 6 + TGW + 32 + 32 + LINE_BYTES + CW + CW;

  typedef struct packed {
    logic [5:0]            thr;
    logic [TGW-1:0]        tag;
    logic [31:0]           rd;
    logic [31:0]           wr;
    logic [LINE_BYTES-1:0] mask;
    logic [CW-1:0]         wipc;
    logic [CW-1:0]         ripc;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ALLOC, S_IPRD, S_IPCHK, S_WB, S_QIP, S_QIPW, S_DONE, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0]  mode_r;
  logic [TGW-1:0] tag_r;
  logic [OW-1:0] off_r;
  logic wr_r;
  logic [47:0] ip_r;
  logic [5:0]  thr_r;
  logic [2:0]  slot_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [EW:0] scan_r;          // issued read index
  logic        rv_r;            // read data valid in pipeline
  logic [EW-1:0] ridx_r;        // index of data on RAM output
  logic        hit_r, free_r;
  logic [EW-1:0] hit_idx_r, free_idx_r;
  rec_t        rec_r;
  logic [6:0]  cnt_r;
  logic [39:0] sum_r;
  logic [63:0] lmask_r;
  logic [47:0] total_r;
  logic [CW:0] ipi_r;
  logic        ipfound_r;

  // entry RAM
  logic          ewe;
  logic [EW-1:0] eaddr_w, eaddr_r;
  rec_t          ewdata, erdata;
  logic [RW-1:0] erdata_raw;
  fslm_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_entry (
    .clk, .we(ewe), .waddr(eaddr_w), .wdata(ewdata), .raddr(eaddr_r), .rdata(erdata_raw));
  assign erdata = rec_t'(erdata_raw);

  // IP RAM: write list then read list
  logic          iwe;
  logic [IW:0]   iaddr_w, iaddr_r;
  logic [47:0]   irdata;
  fslm_ram #(.WIDTH(48), .DEPTH(2*IPD)) u_ips (
    .clk, .we(iwe), .waddr(iaddr_w), .wdata(ip_r), .raddr(iaddr_r), .rdata(irdata));

  logic [EW-1:0] ent;
  assign ent = hit_r ? hit_idx_r : free_idx_r;
  logic [CW-1:0] lcnt;
  assign lcnt = wr_r ? rec_r.wipc : rec_r.ripc;

  function automatic logic [IW:0] ip_addr(input logic w, input logic [EW-1:0] e,
                                         input logic [SW-1:0] s);
    logic [IW:0] a;
    a = {1'b0, IW'(e) * IW'(IP_SLOTS)} + (IW+1)'(s);
    return w ? a : a + (IW+1)'(IPD);
  endfunction

  logic scan_done;
  assign scan_done = scan_r[EW] && !rv_r;
  assign eaddr_r = (state_r == S_SCAN) ? scan_r[EW-1:0] : ent;
  assign iaddr_r = ip_addr(wr_r, ent, ipi_r[SW-1:0]);
  assign eaddr_w = ent;
  assign iaddr_w = ip_addr(wr_r, ent, lcnt[SW-1:0]);
  assign ewe = (state_r == S_WB);
  assign iwe = (state_r == S_WB) && !ipfound_r && (lcnt < CW'(IP_SLOTS));

  always_comb begin
    ewdata = rec_r;
    ewdata.mask = rec_r.mask | (LINE_BYTES'(1) << off_r);
    if (wr_r) begin
      if (rec_r.wr != MAX32) ewdata.wr = rec_r.wr + 32'd1;
      if (!ipfound_r && rec_r.wipc < CW'(IP_SLOTS)) ewdata.wipc = rec_r.wipc + CW'(1);
    end else begin
      if (rec_r.rd != MAX32) ewdata.rd = rec_r.rd + 32'd1;
      if (!ipfound_r && rec_r.ripc < CW'(IP_SLOTS)) ewdata.ripc = rec_r.ripc + CW'(1);
    end
  end

  // sum > floor(total/1000) holds exactly when total < 1000*sum
  logic [49:0] sum_x1000;
  assign sum_x1000 = ({10'd0, sum_r} << 10) - ({10'd0, sum_r} << 4) - ({10'd0, sum_r} << 3);
  logic hot;
  assign hot = (cnt_r >= 7'd2) && ({2'd0, total_r} < sum_x1000);
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      total_r <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_mode; tag_r <= in_address[47:OW]; off_r <= in_address[OW-1:0];
            wr_r <= in_access_is_write; ip_r <= in_instr_pointer;
            thr_r <= in_thread_id; slot_r <= in_ip_slot;
            scan_r <= '0; rv_r <= 1'b0; hit_r <= 1'b0; free_r <= 1'b0;
            cnt_r <= '0; sum_r <= '0; lmask_r <= '0;
            ipi_r <= '0; ipfound_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          rv_r <= !scan_r[EW];
          ridx_r <= scan_r[EW-1:0];
          if (!scan_r[EW]) scan_r <= scan_r + 1'b1;
          if (rv_r && valid_r[ridx_r]) begin
            if (erdata.tag == tag_r) begin
              cnt_r <= cnt_r + 7'd1;
              sum_r <= ({1'b0, sum_r} + {9'd0, erdata.wr} > {1'b0, MAX40}) ? MAX40
                       : sum_r + {8'd0, erdata.wr};
              lmask_r <= lmask_r | 64'(erdata.mask);
              if (erdata.thr == thr_r && !hit_r) begin
                hit_r <= 1'b1; hit_idx_r <= ridx_r; rec_r <= erdata;
              end
            end
          end else if (rv_r && !free_r) begin
            free_r <= 1'b1; free_idx_r <= ridx_r;
          end
          if (scan_done) begin
            out_status <= ST_OK; out_thread_count <= '0; out_line_write_sum <= '0;
            out_hotspot <= 1'b0; out_false_share <= 1'b0; out_rec_reads <= '0;
            out_rec_writes <= '0; out_byte_mask <= '0; out_write_ip_total <= '0;
            out_read_ip_total <= '0; out_ip_value <= '0;
            state_r <= S_DONE;
            case (mode_r)
              MODE_RECORD: begin
                if (32'(thr_r) >= 32'(THREAD_LIMIT) || (!hit_r && !free_r)) begin
                  out_status <= ST_DROP;
                end else if (!hit_r) begin
                  rec_r <= '{thr: thr_r, tag: tag_r, default: '0};
                  valid_r[free_idx_r] <= 1'b1;
                  state_r <= S_WB;
                end else begin
                  state_r <= S_IPRD;
                end
              end
              MODE_QREC: begin
                if (32'(thr_r) >= 32'(THREAD_LIMIT) || !hit_r) out_status <= ST_MISS;
                else begin
                  ipi_r <= (CW+1)'(slot_r[SW-1:0]);
                  state_r <= S_QIP;
                end
              end
              MODE_LINE: begin
                if (cnt_r == '0) out_status <= ST_MISS;
                else begin
                  out_thread_count <= cnt_r; out_line_write_sum <= sum_r;
                  out_hotspot <= hot; out_byte_mask <= lmask_r;
                  out_false_share <= hot && ($countones(lmask_r) > 1);
                end
              end
              default: ;
            endcase
          end
        end
        S_IPRD: begin
          if (ipfound_r || ipi_r >= (CW+1)'(lcnt)) state_r <= S_WB;
          else state_r <= S_IPCHK;
        end
        S_IPCHK: begin
          if (irdata == ip_r) ipfound_r <= 1'b1;
          ipi_r <= ipi_r + 1'b1;
          state_r <= S_IPRD;
        end
        S_WB: begin
          if (wr_r && total_r != MAX48) total_r <= total_r + 48'd1;
          state_r <= S_DONE;
        end
        S_QIP: begin
          wr_r <= wr_r;
          state_r <= S_QIPW;
        end
        S_QIPW: begin
          out_rec_reads <= rec_r.rd; out_rec_writes <= rec_r.wr;
          out_byte_mask <= 64'(rec_r.mask);
          out_write_ip_total <= 4'(rec_r.wipc); out_read_ip_total <= 4'(rec_r.ripc);
          out_ip_value <= ({1'b0, slot_r} < 4'(lcnt) && 32'(slot_r) < 32'(IP_SLOTS))
                          ? irdata : '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FSLM_ASSERT_IMP(a_out_only_in_out, out_valid, state_r == S_OUT, "out_valid outside S_OUT")
  `FSLM_ASSERT_IMP(a_wb_has_slot, state_r == S_WB, hit_r || free_r, "write-back with no entry")
  `FSLM_ASSERT_NXT(a_total_mono, state_r != S_WB, $stable(total_r), "write total moved")
endmodule
